### hw/rtl/sli_pkg.sv
// shared constants, codes and controller/datapath interface types for the sorted list
`default_nettype none

package sli_pkg;

    // list capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed result field widths
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE,
        S_STREAM
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the incoming transaction
        logic search;      // register the slot / match index
        logic update;      // shift the list and adjust the count
        logic fail_out;    // emit a single failure result
        logic stream_out;  // emit the entry at the stream position
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic fail;        // insert into a full list or delete of an absent value
        logic last_elem;   // stream position holds the final result
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/sli_ctrl.sv
// controller state machine sequencing search, update and result streaming
`default_nettype none

module sli_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire sli_pkg::t_dp_stat i_stat,
    output sli_pkg::t_dp_cmd       o_cmd,
    output logic                   busy
);

    sli_pkg::t_state r_state;
    sli_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sli_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            sli_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = sli_pkg::S_SEARCH;
                end
            end
            sli_pkg::S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state      = sli_pkg::S_UPDATE;
            end
            sli_pkg::S_UPDATE: begin
                if (i_stat.fail) begin
                    o_cmd.fail_out = 1'b1;
                    n_state        = sli_pkg::S_IDLE;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state      = sli_pkg::S_STREAM;
                end
            end
            sli_pkg::S_STREAM: begin
                o_cmd.stream_out = 1'b1;
                if (i_stat.last_elem) begin
                    n_state = sli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sli_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/sli_datapath.sv
// list storage, parallel compare, shift update and registered result outputs
`default_nettype none

module sli_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire sli_pkg::t_dp_cmd                      i_cmd,
    input  wire logic                                  i_func,
    input  wire logic signed [sli_pkg::DATA_W-1:0]     i_value,
    output sli_pkg::t_dp_stat                          o_stat,
    output logic                                       o_valid,
    output logic [sli_pkg::STATUS_W-1:0]               o_status,
    output logic signed [sli_pkg::DATA_W-1:0]          o_element,
    output logic [sli_pkg::POS_W-1:0]                  o_position,
    output logic [sli_pkg::COUNT_W-1:0]                o_count,
    output logic                                       o_element_valid,
    output logic                                       o_last
);

    localparam int IW = sli_pkg::IDX_W;
    localparam int CW = sli_pkg::CNT_W;
    localparam int NC = sli_pkg::CAPACITY;

    // list entries, valid below r_count
    logic signed [sli_pkg::DATA_W-1:0] r_mem [NC];
    logic [CW-1:0]                     r_count;

    // captured transaction and search result
    logic                              r_func;
    logic signed [sli_pkg::DATA_W-1:0] r_value;
    logic [IW-1:0]                     r_slot;
    logic                              r_found;
    logic [IW-1:0]                     r_pos;

    // registered result
    logic                              r_o_valid;
    logic [sli_pkg::STATUS_W-1:0]      r_o_status;
    logic signed [sli_pkg::DATA_W-1:0] r_o_element;
    logic [sli_pkg::POS_W-1:0]         r_o_position;
    logic [sli_pkg::COUNT_W-1:0]       r_o_count;
    logic                              r_o_element_valid;
    logic                              r_o_last;

    logic [NC-1:0]                     hit;
    logic [IW-1:0]                     n_slot;
    logic                              n_found;
    logic                              full;

    // per-entry compare: entries larger than the value for insert, equal to it for delete
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            if (r_func == sli_pkg::FUNC_INSERT) begin
                hit[i] = (r_count > CW'(i)) && (r_mem[i] > r_value);
            end else begin
                hit[i] = (r_count > CW'(i)) && (r_mem[i] == r_value);
            end
        end
    end

    // priority pick of the lowest hit, count when none
    always_comb begin
        n_slot  = IW'(r_count);
        n_found = 1'b0;
        for (int i = NC - 1; i >= 0; i--) begin
            if (hit[i]) begin
                n_slot  = IW'(i);
                n_found = 1'b1;
            end
        end
    end

    assign full = (r_count == CW'(NC));

    // status towards the controller
    always_comb begin
        if (r_func == sli_pkg::FUNC_INSERT) begin
            o_stat.fail = full;
        end else begin
            o_stat.fail = !r_found;
        end
        o_stat.last_elem = (r_count == '0) || ((CW'(r_pos) + CW'(1)) == r_count);
    end

    // transaction capture and search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        if (i_cmd.search) begin
            r_slot  <= n_slot;
            r_found <= n_found;
        end
        if (i_cmd.update) begin
            r_pos <= '0;
        end else if (i_cmd.stream_out) begin
            r_pos <= r_pos + IW'(1);
        end
    end

    // list shift on insert or delete
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            for (int i = 0; i < NC; i++) begin
                if (r_func == sli_pkg::FUNC_INSERT) begin
                    if (IW'(i) == r_slot) begin
                        r_mem[i] <= r_value;
                    end else if ((i > 0) && (IW'(i) > r_slot)) begin
                        r_mem[i] <= r_mem[(i > 0) ? i - 1 : 0];
                    end
                end else begin
                    if ((i < NC - 1) && (IW'(i) >= r_slot)) begin
                        r_mem[i] <= r_mem[(i < NC - 1) ? i + 1 : i];
                    end
                end
            end
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.update) begin
            if (r_func == sli_pkg::FUNC_INSERT) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.fail_out || i_cmd.stream_out;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.fail_out) begin
            r_o_status        <= (r_func == sli_pkg::FUNC_INSERT) ?
                                 sli_pkg::ST_FULL : sli_pkg::ST_NOT_FOUND;
            r_o_element       <= '0;
            r_o_position      <= '0;
            r_o_count         <= sli_pkg::COUNT_W'(r_count);
            r_o_element_valid <= 1'b0;
            r_o_last          <= 1'b1;
        end else if (i_cmd.stream_out) begin
            r_o_status <= sli_pkg::ST_DONE;
            r_o_count  <= sli_pkg::COUNT_W'(r_count);
            r_o_last   <= o_stat.last_elem;
            if (r_count == '0) begin
                // empty list after delete
                r_o_element       <= '0;
                r_o_position      <= '0;
                r_o_element_valid <= 1'b0;
            end else begin
                r_o_element       <= r_mem[r_pos];
                r_o_position      <= sli_pkg::POS_W'(r_pos);
                r_o_element_valid <= 1'b1;
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_element       = r_o_element;
    assign o_position      = r_o_position;
    assign o_count         = r_o_count;
    assign o_element_valid = r_o_element_valid;
    assign o_last          = r_o_last;

endmodule

`default_nettype wire

### hw/rtl/sorted_list_insert_delete.sv
// top level of the sorted list with insert and delete by value
// an accepted transaction passes the search and update states; a rejected one emits its single
// result from the update state through the result registers, while a successful one streams
//   one list entry per cycle (one empty result when none is left); busy stays high until the end
// results are strobed for one cycle each on o_valid; the receiver cannot stall
// reset: synchronous active-low i_rst_n empties the list and idles the controller
`default_nettype none

module sorted_list_insert_delete (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_func,
    input  wire logic signed [sli_pkg::DATA_W-1:0] i_value,
    output logic                                   o_valid,
    output logic [sli_pkg::STATUS_W-1:0]           o_status,
    output logic signed [sli_pkg::DATA_W-1:0]      o_element,
    output logic [sli_pkg::POS_W-1:0]              o_position,
    output logic [sli_pkg::COUNT_W-1:0]            o_count,
    output logic                                   o_element_valid,
    output logic                                   o_last
);

    sli_pkg::t_dp_cmd  cmd;
    sli_pkg::t_dp_stat stat;

    // sequencing
    sli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // storage and results
    sli_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_func          (i_func),
        .i_value         (i_value),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_element       (o_element),
        .o_position      (o_position),
        .o_count         (o_count),
        .o_element_valid (o_element_valid),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

### tb/sv/tb_sorted_list_insert_delete.sv
// self-checking testbench for the sorted list with insert and delete by value
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete;

    import sli_pkg::*;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] element;
        logic [POS_W-1:0]         position;
        logic [COUNT_W-1:0]       count;
        logic                     element_valid;
        logic                     last;
    } t_list_result;

    // one row of the directed stimulus; typed rows carry a single known result
    typedef struct {
        logic                     func;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic                     element_valid;
    } t_op_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_func = FUNC_INSERT;
    logic signed [DATA_W-1:0]  i_value = '0;
    logic                      o_valid;
    logic [STATUS_W-1:0]       o_status;
    logic signed [DATA_W-1:0]  o_element;
    logic [POS_W-1:0]          o_position;
    logic [COUNT_W-1:0]        o_count;
    logic                      o_element_valid;
    logic                      o_last;

    // typed expectation travelling alongside the transaction on the input side
    bit                        row_typed = 1'b0;
    logic [STATUS_W-1:0]       row_status = ST_DONE;
    logic [COUNT_W-1:0]        row_count = '0;
    logic                      row_valid = 1'b0;

    // shadow copy of the list kept by the predictor
    logic signed [DATA_W-1:0]  stored_vals [CAPACITY];
    int                        stored_len = 0;

    t_list_result              expected_results [$];
    t_op_row                   directed_ops [$];

    int unsigned               err_cnt = 0;
    int unsigned               results_checked = 0;
    int unsigned               n_insert = 0;
    int unsigned               n_delete = 0;
    int unsigned               n_full = 0;
    int unsigned               n_absent = 0;
    int unsigned               n_emptied = 0;
    int                        burst_left = 0;

    sorted_list_insert_delete i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_element      (o_element),
        .o_position     (o_position),
        .o_count        (o_count),
        .o_element_valid(o_element_valid),
        .o_last         (o_last)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_list_result make_result(input logic [STATUS_W-1:0] status,
                                                 input logic [DATA_W-1:0] element,
                                                 input logic [POS_W-1:0] position,
                                                 input logic [COUNT_W-1:0] count,
                                                 input logic element_valid,
                                                 input logic last);
        t_list_result r;
        r.status        = status;
        r.element       = element;
        r.position      = position;
        r.count         = count;
        r.element_valid = element_valid;
        r.last          = last;
        return r;
    endfunction

    // apply one operation to the shadow list, returning the status it ends with
    function automatic logic [STATUS_W-1:0] apply_list_op(input logic func,
                                                          input logic signed [DATA_W-1:0] value);
        int slot;
        int hit;
        slot = stored_len;
        hit  = -1;
        if (func == FUNC_INSERT) begin
            if (stored_len >= CAPACITY)
                return ST_FULL;
            // new value goes after any equal entries
            for (int i = 0; i < stored_len; i++) begin
                if (stored_vals[i] > value) begin
                    slot = i;
                    break;
                end
            end
            for (int i = stored_len; i > slot; i--)
                stored_vals[i] = stored_vals[i-1];
            stored_vals[slot] = value;
            stored_len++;
        end else begin
            for (int i = 0; i < stored_len; i++) begin
                if (stored_vals[i] == value) begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0)
                return ST_NOT_FOUND;
            for (int i = hit; i + 1 < stored_len; i++)
                stored_vals[i] = stored_vals[i+1];
            stored_len--;
        end
        return ST_DONE;
    endfunction

    // expected results of one transaction, given its status
    function automatic void queue_listing(input logic [STATUS_W-1:0] status);
        if (status != ST_DONE || stored_len == 0) begin
            expected_results.push_back(make_result(status, '0, '0, COUNT_W'(stored_len),
                                                   1'b0, 1'b1));
            return;
        end
        for (int i = 0; i < stored_len; i++)
            expected_results.push_back(make_result(ST_DONE, stored_vals[i], POS_W'(i),
                                                   COUNT_W'(stored_len), 1'b1,
                                                   i == stored_len - 1));
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // result checking first, then prediction for a transaction accepted at this edge
    always @(posedge i_clk) begin : result_monitor
        t_list_result want;
        logic [STATUS_W-1:0] st;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: status %0d element 'h%0h",
                           o_status, o_element);
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(o_status));
                    check_field("element", want.element, o_element);
                    check_field("position", DATA_W'(want.position), DATA_W'(o_position));
                    check_field("count", DATA_W'(want.count), DATA_W'(o_count));
                    check_field("element_valid", DATA_W'(want.element_valid),
                                DATA_W'(o_element_valid));
                    check_field("last", DATA_W'(want.last), DATA_W'(o_last));
                    results_checked++;
                end
            end
            if (start && !busy) begin
                st = apply_list_op(i_func, i_value);
                if (i_func == FUNC_INSERT)
                    n_insert++;
                else
                    n_delete++;
                if (st == ST_FULL)
                    n_full++;
                if (st == ST_NOT_FOUND)
                    n_absent++;
                if (st == ST_DONE && stored_len == 0)
                    n_emptied++;
                if (row_typed)
                    expected_results.push_back(make_result(row_status,
                                                           row_valid ? i_value : '0, '0,
                                                           row_count, row_valid, 1'b1));
                else
                    queue_listing(st);
            end
        end
    end

    // sender pacing: bursts of random length with random gaps between them
    task automatic pace();
        @(posedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
        burst_left--;
    endtask

    // present one transaction and hold it until the block takes it
    task automatic issue(input logic func, input logic [DATA_W-1:0] value, input bit typed,
                         input logic [STATUS_W-1:0] status, input logic [COUNT_W-1:0] count,
                         input logic element_valid);
        start      <= 1'b1;
        i_func     <= func;
        i_value    <= value;
        row_typed  <= typed;
        row_status <= status;
        row_count  <= count;
        row_valid  <= element_valid;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        // junk on the payload while idle
        start   <= 1'b0;
        i_func  <= 1'($urandom);
        i_value <= $urandom;
    endtask

    task automatic add_row(input logic func, input logic [DATA_W-1:0] value, input bit typed,
                           input logic [STATUS_W-1:0] status, input logic [COUNT_W-1:0] count,
                           input logic element_valid);
        t_op_row r;
        r.func          = func;
        r.value         = value;
        r.typed         = typed;
        r.status        = status;
        r.count         = count;
        r.element_valid = element_valid;
        directed_ops.push_back(r);
    endtask

    // random value: wide, narrow band for duplicates, one already held, or an extreme
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4, 5: v = $urandom_range(0, 12) - 6;
            6, 7, 8: v = (stored_len > 0) ? stored_vals[$urandom_range(0, stored_len - 1)]
                                          : $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin : stimulus
        logic              op;
        logic [DATA_W-1:0] val;
        bit                draining;
        draining = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: empty list, extremes, ordering, duplicates, fill to full
        add_row(FUNC_DELETE, 32'h0000_0000, 1, ST_NOT_FOUND, 5'd0, 1'b0);
        add_row(FUNC_INSERT, 32'h7FFF_FFFF, 1, ST_DONE, 5'd1, 1'b1);
        add_row(FUNC_DELETE, 32'h7FFF_FFFF, 1, ST_DONE, 5'd0, 1'b0);
        add_row(FUNC_INSERT, 32'h8000_0000, 1, ST_DONE, 5'd1, 1'b1);
        add_row(FUNC_INSERT, 32'h7FFF_FFFF, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h0000_0000, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'hFFFF_FFFF, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h0000_0000, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_DELETE, 32'h0000_0005, 1, ST_NOT_FOUND, 5'd5, 1'b0);
        add_row(FUNC_DELETE, 32'h0000_0000, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h0000_0001, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'hFFFF_FFFE, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h0000_0002, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h5555_5555, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'hAAAA_AAAA, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h0000_0064, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'hFFFF_FF9C, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h8000_0001, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h7FFF_FFFE, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h0000_0007, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h0000_0007, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h0000_0003, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_INSERT, 32'h0000_0000, 1, ST_FULL, 5'd16, 1'b0);
        add_row(FUNC_DELETE, 32'h8000_0000, 0, ST_DONE, '0, 1'b0);
        add_row(FUNC_DELETE, 32'h7FFF_FFFF, 0, ST_DONE, '0, 1'b0);

        foreach (directed_ops[k]) begin
            pace();
            issue(directed_ops[k].func, directed_ops[k].value, directed_ops[k].typed,
                  directed_ops[k].status, directed_ops[k].count,
                  directed_ops[k].element_valid);
        end

        // random part: the list swings between filling and draining
        for (int n = 0; n < 105; n++) begin
            pace();
            if (stored_len == CAPACITY)
                draining = 1'b1;
            else if (stored_len == 0)
                draining = 1'b0;
            else if ($urandom_range(0, 14) == 0)
                draining = !draining;
            op  = ($urandom_range(0, 99) < (draining ? 70 : 30)) ? FUNC_DELETE : FUNC_INSERT;
            val = pick_value();
            issue(op, val, 1'b0, ST_DONE, '0, 1'b0);
        end

        // drain outstanding results, then watch for strays
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d inserts and %0d deletes (%0d rejected as full, %0d not found, %0d emptied)",
                 n_insert, n_delete, n_full, n_absent, n_emptied);
        $display("%0d result transactions checked, %0d errors", results_checked, err_cnt);
        if (err_cnt == 0)
            $display("sorted_list_insert_delete verification clean");
        else
            $display("sorted_list_insert_delete verification failed");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #200000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("sorted_list_insert_delete verification failed");
        $finish;
    end

endmodule
